### rtl/rgba_live_effect_stream_core_defines.svh
// assertion macros for the rgba live effect stream checker
// expects clk and rst in the scope of use
`ifndef RGBA_LIVE_EFFECT_STREAM_CORE_DEFINES_SVH
`define RGBA_LIVE_EFFECT_STREAM_CORE_DEFINES_SVH

// same-cycle implication
`define RLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rle_pkg.sv
// shared types, codes and helper functions of the rgba live effect stream
// no dependencies
package rle_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int MAX_RESULTS    = 61;
  localparam int LEVEL_MAX      = 100;
  localparam int BRIGHT_BIAS    = 50;
  localparam int CFG_DATA_W     = 13;

  localparam logic [1:0] MODE_BRIGHT = 2'd0;
  localparam logic [1:0] MODE_PIXEL  = 2'd1;
  localparam logic [1:0] MODE_GLITCH = 2'd2;

  typedef enum logic [1:0] {
    CFG_MODE      = 2'd0,
    CFG_INTENSITY = 2'd1,
    CFG_WIDTH     = 2'd2,
    CFG_HEIGHT    = 2'd3
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_RD_S,
    S_RD_B,
    S_CAP,
    S_PCAP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       last_of_run;
    logic       row_end;
    logic       frame_end;
  } pixel_out_t;

  // 1 + lvl*63/100, divide by 100 as multiply by 5243 and shift by 19
  function automatic logic [6:0] block_size(input logic [6:0] lvl);
    logic [12:0] v;
    logic [25:0] p;
    v = 13'(lvl) * 13'd63;
    p = 26'(v) * 26'd5243;
    return 7'(p[25:19]) + 7'd1;
  endfunction

  // lvl*30/100 = lvl*3/10, divide by 10 as multiply by 205 and shift by 11
  function automatic logic [4:0] glitch_shift(input logic [6:0] lvl);
    logic [8:0]  v;
    logic [16:0] p;
    v = 9'(lvl) * 9'd3;
    p = 17'(v) * 17'd205;
    return p[15:11];
  endfunction

endpackage

### rtl/rle_line_mem.sv
// single-port-write, single-port-read line memory, registered read
// no dependencies
module rle_line_mem #(
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/rle_offset_div.sv
// restoring divider, one quotient bit per cycle, remainder only
// used for the glitch row offset; no dependencies
module rle_offset_div #(
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [5:0]    divisor,
  output logic          done,
  output logic [5:0]    rem
);

  localparam int CNTW = $clog2(DW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   dvd;
  logic [5:0]      dsr;
  logic [6:0]      trial;

  assign trial = {rem, dvd[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNTW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DW);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DW-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem <= 6'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[5:0];
      end
    end
  end

endmodule

### rtl/rgba_live_effect_stream_core.sv
// top level of the rgba live effect stream: sequencer, registers, datapath
// uses rle_pkg, rle_line_mem, rle_offset_div
//
// One pixel beat is taken at a time. Brightness goes from the accept
// straight to the result beat, pixelate too on a block's first row, and on
// its other rows through one line memory read. Glitch writes the pixel to
// the line memory in the accept cycle, then for each result it releases
// steps through the check, three reads of the single memory read port for
// red, green/alpha and blue (the check issues the red one), a capture and
// the result beat, or through the check alone when it releases none; on
// every 16th row with a nonzero shift the first pixel also waits for the
// row offset from the bit-serial remainder unit. Each result beat waits for
// out_ready. The line memory needs no clearing after reset. Any register
// write restarts the frame at row 0, column 0.
module rgba_live_effect_stream_core #(
  parameter int MAX_WIDTH  = rle_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rle_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rle_pkg::pixel_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rle_pkg::pixel_out_t             out_data,
  input  logic                            cfg_write,
  input  logic [1:0]                      cfg_index,
  input  logic [rle_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT);
  localparam int SX = CW + 2;
  localparam int DW = $clog2((MAX_HEIGHT - 1) * 31 + rle_pkg::LEVEL_MAX + 1);

  // registers
  logic [1:0]  mode;
  logic [6:0]  intensity;
  logic [11:0] frame_width;
  logic [12:0] frame_height;

  logic [CW-1:0]     in_column;
  logic [HW-1:0]     in_row;
  logic [CW:0]       out_column;
  logic [5:0]        block_column_count;
  logic [5:0]        block_row_count;
  logic [31:0]       held_block_pixel;
  logic signed [6:0] row_offset;

  logic [CW-1:0] cur_col;
  logic [HW-1:0] cur_row;
  logic [5:0]    nres;
  logic [31:0]   gpix;

  rle_pkg::state_t state, state_next;

  // derived settings
  logic [6:0]  lvl;
  logic [6:0]  blk;
  logic [4:0]  shift;
  logic [CW:0] eff_w;
  logic [CW-1:0] wm1;
  logic [HW:0] eff_h;
  logic [HW-1:0] hm1;
  logic        glitch;

  assign lvl    = (intensity > 7'(rle_pkg::LEVEL_MAX)) ? 7'(rle_pkg::LEVEL_MAX) : intensity;
  assign blk    = rle_pkg::block_size(lvl);
  assign shift  = rle_pkg::glitch_shift(lvl);
  assign glitch = mode[1];

  always_comb begin
    if (frame_width == '0) begin
      eff_w = (CW+1)'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      eff_w = (CW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (CW+1)'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = (HW+1)'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      eff_h = (HW+1)'(MAX_HEIGHT);
    end else begin
      eff_h = (HW+1)'(frame_height);
    end
  end

  assign wm1 = CW'(eff_w - (CW+1)'(1));
  assign hm1 = HW'(eff_h - (HW+1)'(1));

  // glitch source columns {red, green/alpha, blue} for result column x
  function automatic logic [3*CW-1:0] glitch_cols(input logic [CW:0] x,
                                                  input logic [CW-1:0] wlast,
                                                  input logic [4:0] sh_amt,
                                                  input logic signed [6:0] offs);
    logic signed [SX-1:0] s;
    logic signed [SX-1:0] r;
    logic signed [SX-1:0] b;
    logic signed [SX-1:0] wl;
    logic signed [SX-1:0] sh;
    wl = $signed({2'b00, wlast});
    sh = $signed({{(SX-5){1'b0}}, sh_amt});
    s  = $signed({1'b0, x}) + SX'(offs);
    if (s < 0) s = '0;
    if (s > wl) s = wl;
    r = s + sh;
    if (r > wl) r = wl;
    b = s - sh;
    if (b < 0) b = '0;
    return {r[CW-1:0], s[CW-1:0], b[CW-1:0]};
  endfunction

  logic [3*CW-1:0] cols_cur, cols_nxt;
  logic [CW-1:0]   xr_cur, xs_cur, xb_cur, xr_nxt;
  logic [CW:0]     out_column_inc;
  logic            ok_cur, ok_nxt;

  assign out_column_inc = out_column + (CW+1)'(1);
  assign cols_cur = glitch_cols(out_column, wm1, shift, row_offset);
  assign cols_nxt = glitch_cols(out_column_inc, wm1, shift, row_offset);
  assign xr_cur   = cols_cur[3*CW-1:2*CW];
  assign xs_cur   = cols_cur[2*CW-1:CW];
  assign xb_cur   = cols_cur[CW-1:0];
  assign xr_nxt   = cols_nxt[3*CW-1:2*CW];
  assign ok_cur = (out_column < eff_w) && (nres < 6'(rle_pkg::MAX_RESULTS))
                  && (xr_cur <= cur_col);
  assign ok_nxt = (out_column_inc < eff_w)
                  && ((7'(nres) + 7'd1) < 7'(rle_pkg::MAX_RESULTS))
                  && (xr_nxt <= cur_col);

  // input pixel and brightness
  logic [31:0] px;
  logic signed [9:0] bias;

  assign px   = {in_data.alpha, in_data.blue, in_data.green, in_data.red};
  assign bias = $signed({3'b000, lvl}) - 10'(rle_pkg::BRIGHT_BIAS);

  function automatic logic [7:0] sat8(input logic [7:0] ch, input logic signed [9:0] d);
    logic signed [9:0] v;
    v = $signed({2'b00, ch}) + d;
    if (v < 0) return 8'd0;
    if (v > 10'sd255) return 8'd255;
    return v[7:0];
  endfunction

  // pixelate bookkeeping
  logic        accept;
  logic        row_last;
  logic [31:0] held_next;
  logic [6:0]  bcc_inc, brc_inc;

  assign accept    = in_valid && in_ready;
  assign row_last  = (in_column == wm1);
  assign held_next = (block_row_count == '0 && block_column_count == '0) ? px
                                                                         : held_block_pixel;
  assign bcc_inc   = 7'(block_column_count) + 7'd1;
  assign brc_inc   = 7'(block_row_count) + 7'd1;

  // line memory
  logic          mem_wr_en;
  logic [31:0]   mem_wr_data;
  logic          mem_rd_en;
  logic [CW-1:0] mem_rd_addr;
  logic [31:0]   mem_rd_data;

  assign mem_wr_en   = accept && (glitch || (mode == rle_pkg::MODE_PIXEL
                                             && block_row_count == '0));
  assign mem_wr_data = glitch ? px : held_next;

  rle_line_mem #(.DEPTH(MAX_WIDTH)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (in_column),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // row offset remainder unit
  logic          div_start;
  logic          div_done;
  logic [5:0]    div_rem;
  logic [DW-1:0] div_dividend;
  logic          need_div;

  assign div_dividend = DW'(in_row) * DW'(31) + DW'(lvl);
  assign need_div     = (in_column == '0) && (shift != '0) && (in_row[3:0] == 4'd0);

  rle_offset_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  ({shift, 1'b1}),
    .done     (div_done),
    .rem      (div_rem)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rle_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = xr_cur;
    div_start   = 1'b0;
    unique case (state)
      rle_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (mode == rle_pkg::MODE_BRIGHT) begin
            state_next = rle_pkg::S_EMIT;
          end else if (mode == rle_pkg::MODE_PIXEL) begin
            if (block_row_count == '0) begin
              state_next = rle_pkg::S_EMIT;
            end else begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = in_column;
              state_next  = rle_pkg::S_PCAP;
            end
          end else if (need_div) begin
            div_start  = 1'b1;
            state_next = rle_pkg::S_DIV;
          end else begin
            state_next = rle_pkg::S_CHECK;
          end
        end
      end
      rle_pkg::S_DIV: begin
        if (div_done) state_next = rle_pkg::S_CHECK;
      end
      rle_pkg::S_CHECK: begin
        if (ok_cur) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = xr_cur;
          state_next  = rle_pkg::S_RD_S;
        end else begin
          state_next = rle_pkg::S_IDLE;
        end
      end
      rle_pkg::S_RD_S: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = xs_cur;
        state_next  = rle_pkg::S_RD_B;
      end
      rle_pkg::S_RD_B: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = xb_cur;
        state_next  = rle_pkg::S_CAP;
      end
      rle_pkg::S_CAP:  state_next = rle_pkg::S_EMIT;
      rle_pkg::S_PCAP: state_next = rle_pkg::S_EMIT;
      rle_pkg::S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = (glitch && !out_data.last_of_run) ? rle_pkg::S_CHECK
                                                         : rle_pkg::S_IDLE;
        end
      end
      default: state_next = rle_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= rle_pkg::MODE_BRIGHT;
      intensity          <= 7'd50;
      frame_width        <= 12'd640;
      frame_height       <= 13'd480;
      in_column          <= '0;
      in_row             <= '0;
      out_column         <= '0;
      block_column_count <= '0;
      block_row_count    <= '0;
      held_block_pixel   <= '0;
      row_offset         <= '0;
      nres               <= '0;
    end else if (cfg_write) begin
      unique case (rle_pkg::cfg_index_t'(cfg_index))
        rle_pkg::CFG_MODE:      mode         <= cfg_data[1:0];
        rle_pkg::CFG_INTENSITY: intensity    <= cfg_data[6:0];
        rle_pkg::CFG_WIDTH:     frame_width  <= cfg_data[11:0];
        rle_pkg::CFG_HEIGHT:    frame_height <= cfg_data[12:0];
        default: ;
      endcase
      in_column          <= '0;
      in_row             <= '0;
      out_column         <= '0;
      block_column_count <= '0;
      block_row_count    <= '0;
    end else begin
      if (accept) begin
        nres <= '0;
        if (row_last) begin
          in_column <= '0;
          in_row    <= (in_row == hm1) ? '0 : in_row + HW'(1);
        end else begin
          in_column <= in_column + CW'(1);
        end
        if (mode == rle_pkg::MODE_PIXEL) begin
          held_block_pixel <= held_next;
          block_column_count <= (bcc_inc >= blk || row_last) ? '0 : bcc_inc[5:0];
          if (row_last) begin
            block_row_count <= (brc_inc >= blk || in_row == hm1) ? '0 : brc_inc[5:0];
          end
        end else if (row_last && in_row == hm1) begin
          block_row_count <= '0;
        end
        if (glitch && in_column == '0 && !need_div) begin
          row_offset <= '0;
        end
      end
      if (state == rle_pkg::S_DIV && div_done) begin
        row_offset <= $signed({1'b0, div_rem}) - $signed({2'b00, shift});
      end
      if (state == rle_pkg::S_CHECK && !ok_cur && cur_col == wm1) begin
        out_column <= '0;
      end
      if (state == rle_pkg::S_EMIT && out_ready && glitch) begin
        nres <= nres + 6'd1;
        if (out_data.last_of_run && cur_col == wm1) begin
          out_column <= '0;
        end else begin
          out_column <= out_column_inc;
        end
      end
    end
  end

  // result and capture registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_col              <= in_column;
      cur_row              <= in_row;
      out_data.last_of_run <= 1'b1;
      out_data.row_end     <= row_last;
      out_data.frame_end   <= row_last && (in_row == hm1);
      if (mode == rle_pkg::MODE_BRIGHT) begin
        out_data.out_red   <= sat8(in_data.red, bias);
        out_data.out_green <= sat8(in_data.green, bias);
        out_data.out_blue  <= sat8(in_data.blue, bias);
        out_data.out_alpha <= in_data.alpha;
      end else begin
        out_data.out_red   <= held_next[7:0];
        out_data.out_green <= held_next[15:8];
        out_data.out_blue  <= held_next[23:16];
        out_data.out_alpha <= held_next[31:24];
      end
    end
    unique case (state)
      rle_pkg::S_RD_S: gpix[7:0] <= mem_rd_data[7:0];
      rle_pkg::S_RD_B: begin
        gpix[15:8]  <= mem_rd_data[15:8];
        gpix[31:24] <= mem_rd_data[31:24];
      end
      rle_pkg::S_CAP: begin
        out_data.out_red     <= gpix[7:0];
        out_data.out_green   <= gpix[15:8];
        out_data.out_blue    <= mem_rd_data[23:16];
        out_data.out_alpha   <= gpix[31:24];
        out_data.last_of_run <= !ok_nxt;
        out_data.row_end     <= (out_column[CW-1:0] == wm1);
        out_data.frame_end   <= (out_column[CW-1:0] == wm1) && (cur_row == hm1);
      end
      rle_pkg::S_PCAP: begin
        out_data.out_red   <= mem_rd_data[7:0];
        out_data.out_green <= mem_rd_data[15:8];
        out_data.out_blue  <= mem_rd_data[23:16];
        out_data.out_alpha <= mem_rd_data[31:24];
      end
      default: ;
    endcase
  end

endmodule

### rtl/rle_checker.sv
// port-level checks for the rgba live effect stream, bound to the top level
// uses rle_pkg and the assertion macros header
`include "rgba_live_effect_stream_core_defines.svh"

module rle_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input rle_pkg::pixel_out_t out_data,
  input logic                cfg_write
);

  // a stalled result beat holds
  `RLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

  // one pixel in flight: no new input while a result is offered
  `RLE_ASSERT_NOW(a_one_in_flight, out_valid, !in_ready, "input taken while a result waits")

  // frame end only on a row end
  `RLE_ASSERT_NOW(a_frame_row, out_valid && out_data.frame_end, out_data.row_end, "frame end without row end")

  // a register write leaves an idle block idle
  `RLE_ASSERT_NEXT(a_cfg_idle, cfg_write && in_ready && !in_valid, in_ready && !out_valid, "block left idle after register write")

endmodule

bind rgba_live_effect_stream_core rle_checker u_rle_checker (.*);
